### sv/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants for the chunked body decoder
// Byte type, line delimiter characters and hex digit decoding.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte CH_CR = 8'h0D;
    localparam t_byte CH_LF = 8'h0A;

    // Digit value in [3:0]; bit 4 set means not a hex digit.
    typedef logic [4:0] t_hex;

    function automatic t_hex hex_value(input t_byte b);
        t_byte t;
        t = 8'h00;
        if (b inside {[8'h30:8'h39]}) begin
            t = b - 8'h30;
            return {1'b0, t[3:0]};
        end
        if (b inside {[8'h61:8'h66]}) begin
            t = b - 8'h57;
            return {1'b0, t[3:0]};
        end
        if (b inside {[8'h41:8'h46]}) begin
            t = b - 8'h37;
            return {1'b0, t[3:0]};
        end
        return 5'h10;
    endfunction

endpackage

### sv/hcbd_in_if.sv
// ----------------------------------------------------------------------------
// hcbd_in_if: raw body byte channel
// Valid/ready channel carrying one byte of the chunked message per beat.
// ----------------------------------------------------------------------------
interface hcbd_in_if import hcbd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

### sv/hcbd_out_if.sv
// ----------------------------------------------------------------------------
// hcbd_out_if: decoded result channel
// Valid/ready channel carrying a payload byte or an end-of-body marker.
// ----------------------------------------------------------------------------
interface hcbd_out_if import hcbd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  end_of_body;
    logic  size_overflow;

    modport source (output valid, output out_byte, output end_of_body,
                    output size_overflow, input ready);
    modport sink   (input valid, input out_byte, input end_of_body,
                    input size_overflow, output ready);
endinterface

### sv/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer body decoder
// Strips chunk size lines and trailing CR LF, forwards payload bytes and
// marks the end of each message.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries the raw chunked body, one byte per beat. o_out carries one
//   beat per payload byte (end_of_body = 0) and one beat with end_of_body = 1
//   and out_byte = 0 after the CR LF following a zero-size chunk. Size-line
//   bytes and the two bytes after each chunk's data produce no beat.
//   size_overflow reports whether any chunk size of the current message
//   saturated at SIZE_BITS bits.
//   Throughput: one byte per cycle while o_out takes every result. An
//   accepted byte lands in an input register and is decoded from there
//   into the output register once that register is empty or being taken.
//   Stall: while o_out is held off, an empty input register still takes one
//   more byte; after that i_in.ready drops until the result is taken.
//   Reset (synchronous, i_rst_n low): returns to the size-line phase with
//   an empty pipeline and all counters and flags cleared.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder import hcbd_pkg::*; #(
    parameter int SIZE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbd_in_if.sink     i_in,
    hcbd_out_if.source  o_out
);

    typedef enum logic [1:0] {
        PH_SIZE = 2'd0,
        PH_DATA = 2'd1,
        PH_SKIP = 2'd2
    } t_phase;

    typedef logic [SIZE_BITS-1:0] t_size;

    // input stage
    logic  r_in_valid;
    t_byte r_in_byte;

    // decoder state
    t_phase r_phase,    n_phase;
    t_size  r_acc,      n_acc;
    t_size  r_rem,      n_rem;
    logic   r_prev_cr,  n_prev_cr;
    logic   r_trailer,  n_trailer;
    logic   r_final,    n_final;
    logic   r_ovf,      n_ovf;

    // output stage
    logic  r_out_valid;
    t_byte r_out_byte,  n_out_byte;
    logic  r_out_eob,   n_out_eob;
    logic  r_out_ovf,   n_out_ovf;
    logic  n_produce;

    logic  advance;
    t_hex  digit;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign digit      = hex_value(r_in_byte);

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_rem      = r_rem;
        n_prev_cr  = r_prev_cr;
        n_trailer  = r_trailer;
        n_final    = r_final;
        n_ovf      = r_ovf;
        n_produce  = 1'b0;
        n_out_byte = r_in_byte;
        n_out_eob  = 1'b0;
        n_out_ovf  = r_ovf;
        case (r_phase)
            PH_DATA: begin
                n_produce = 1'b1;
                n_rem     = r_rem - t_size'(1);
                if (r_rem == t_size'(1)) begin
                    n_phase   = PH_SKIP;
                    n_trailer = 1'b0;
                end
            end
            PH_SKIP: begin
                if (!r_trailer) begin
                    n_trailer = 1'b1;
                end else begin
                    n_trailer = 1'b0;
                    n_phase   = PH_SIZE;
                    if (r_final) begin
                        n_produce  = 1'b1;
                        n_out_byte = 8'h00;
                        n_out_eob  = 1'b1;
                        n_final    = 1'b0;
                        n_ovf      = 1'b0;
                    end
                end
            end
            default: begin
                n_phase = PH_SIZE;
                if (r_in_byte == CH_LF && r_prev_cr) begin
                    n_prev_cr = 1'b0;
                    n_rem     = r_acc;
                    n_acc     = '0;
                    n_trailer = 1'b0;
                    if (r_acc == '0) begin
                        n_final = 1'b1;
                        n_phase = PH_SKIP;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_prev_cr = (r_in_byte == CH_CR);
                    if (!digit[4]) begin
                        // a nonzero top nibble would shift out: saturate
                        if (r_acc[SIZE_BITS-1 -: 4] != 4'h0) begin
                            n_acc = '1;
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = {r_acc[SIZE_BITS-5:0], digit[3:0]};
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_SIZE;
            r_acc       <= '0;
            r_rem       <= '0;
            r_prev_cr   <= 1'b0;
            r_trailer   <= 1'b0;
            r_final     <= 1'b0;
            r_ovf       <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= n_produce;
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_rem       <= n_rem;
                r_prev_cr   <= n_prev_cr;
                r_trailer   <= n_trailer;
                r_final     <= n_final;
                r_ovf       <= n_ovf;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
        end
        if (advance) begin
            r_out_byte <= n_out_byte;
            r_out_eob  <= n_out_eob;
            r_out_ovf  <= n_out_ovf;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.end_of_body   = r_out_eob;
    assign o_out.size_overflow = r_out_ovf;

    // data phase is never entered or held with an empty count
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_rem != '0)
        else $error("data phase with zero byte count");

    // a payload byte always yields a beat
    a_data_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_phase == PH_DATA |=> r_out_valid && !r_out_eob)
        else $error("payload byte dropped");

    // end marker carries a zero byte
    a_eob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_eob |-> r_out_byte == 8'h00)
        else $error("end marker with nonzero byte");

    // second skip byte only counted inside the skip phase
    a_trailer_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trailer |-> r_phase == PH_SKIP)
        else $error("trailer count set outside skip phase");

    // a held result is not lost while the sink stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_byte))
        else $error("stalled result lost");

endmodule

### tb/tb_http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder: self-checking bench for the chunked decoder
// Feeds chunked message bodies (a few directed, then random well-formed
// messages with junk, lone CR/LF and odd trailers mixed in) and checks every
// output beat against a cycle-free model of the decoder kept in the bench.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;
    import hcbd_pkg::*;

    localparam int          SZ        = 32;
    localparam logic [63:0] SIZE_SAT  = (64'd1 << SZ) - 64'd1;
    localparam int          TAIL_LEN  = 60;    // last bytes go without idling
    localparam int          HOLD_LEN  = 64;    // long receiver hold-off
    localparam int          RAND_LEN  = 400;

    typedef enum logic [1:0] {SIZE_LINE, CHUNK_DATA, CHUNK_TAIL} t_dec_phase;

    typedef struct packed {
        t_byte data;
        logic  eob;
        logic  ovf;
    } t_dec_beat;

    logic i_clk;
    logic i_rst_n;

    hcbd_in_if  in_ch ();
    hcbd_out_if out_ch ();

    http_chunked_body_decoder #(.SIZE_BITS(SZ)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_byte     body_q[$];
    t_dec_beat decoded_q[$];

    // decoder state as the bench sees it
    t_dec_phase  m_phase;
    logic [63:0] m_size;
    logic [63:0] m_left;
    logic        m_cr;
    logic        m_tail;
    logic        m_last;
    logic        m_ovf;

    int n_sent;
    int n_payload;
    int n_end;
    int n_ovf_beats;
    int n_err;
    int src_gap;
    int sink_gap;
    logic stall_hold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 100000);
        $display("http_chunked_body_decoder test failed");
        $finish;
    end

    // Advance the decoder by one body byte and queue the beat it produces.
    task automatic decode_byte(input t_byte b);
        t_dec_beat r;
        int        nib;
        case (m_phase)
            CHUNK_DATA: begin
                r = '{data: b, eob: 1'b0, ovf: m_ovf};
                decoded_q.push_back(r);
                m_left = m_left - 1;
                if (m_left == 0) begin
                    m_phase = CHUNK_TAIL;
                    m_tail  = 1'b0;
                end
            end
            CHUNK_TAIL: begin
                if (!m_tail) begin
                    m_tail = 1'b1;
                end else begin
                    m_tail  = 1'b0;
                    m_phase = SIZE_LINE;
                    if (m_last) begin
                        r = '{data: 8'h00, eob: 1'b1, ovf: m_ovf};
                        decoded_q.push_back(r);
                        m_last = 1'b0;
                        m_ovf  = 1'b0;
                    end
                end
            end
            default: begin
                m_phase = SIZE_LINE;
                if (b == CH_LF && m_cr) begin
                    m_cr   = 1'b0;
                    m_left = m_size;
                    m_size = 64'd0;
                    m_tail = 1'b0;
                    if (m_left == 0) begin
                        m_last  = 1'b1;
                        m_phase = CHUNK_TAIL;
                    end else begin
                        m_phase = CHUNK_DATA;
                    end
                end else begin
                    m_cr = (b == CH_CR);
                    nib  = -1;
                    if (b >= 8'h30 && b <= 8'h39) nib = b - 8'h30;
                    else if (b >= 8'h61 && b <= 8'h66) nib = b - 8'h61 + 10;
                    else if (b >= 8'h41 && b <= 8'h46) nib = b - 8'h41 + 10;
                    if (nib >= 0) begin
                        if (m_size > (SIZE_SAT - nib) / 16) begin
                            m_size = SIZE_SAT;
                            m_ovf  = 1'b1;
                        end else begin
                            m_size = m_size * 16 + nib;
                        end
                    end
                end
            end
        endcase
    endtask

    // ---------------- stimulus builders ----------------
    task automatic push_text(input string s);
        foreach (s[i]) body_q.push_back(t_byte'(s[i]));
    endtask

    task automatic push_crlf();
        body_q.push_back(CH_CR);
        body_q.push_back(CH_LF);
    endtask

    // any byte that is neither a hex digit nor LF
    function automatic t_byte junk_byte();
        t_byte b;
        do begin
            b = t_byte'($urandom_range(0, 255));
        end while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                   (b >= 8'h61 && b <= 8'h66) || b == CH_LF);
        return b;
    endfunction

    task automatic add_size_line(input int unsigned sz);
        t_byte       digits[$];
        int unsigned v;
        int          n;
        string       ext_chars;
        v = sz;
        ext_chars = "ghijkxyz=_ -;";
        do begin
            n = v % 16;
            if (n < 10) digits.push_front(t_byte'(8'h30 + n));
            else if ($urandom_range(0, 1)) digits.push_front(t_byte'(8'h41 + n - 10));
            else digits.push_front(t_byte'(8'h61 + n - 10));
            v = v / 16;
        end while (v != 0);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) digits.push_front(8'h30);
        foreach (digits[i]) begin
            if ($urandom_range(0, 9) == 0) body_q.push_back(junk_byte());
            body_q.push_back(digits[i]);
        end
        if ($urandom_range(0, 3) == 0) begin
            body_q.push_back(8'h3B);
            repeat ($urandom_range(1, 4))
                body_q.push_back(
                    t_byte'(ext_chars[$urandom_range(0, ext_chars.len() - 1)]));
        end
        // stray CR that is not a line end
        if ($urandom_range(0, 11) == 0) begin
            body_q.push_back(CH_CR);
            body_q.push_back(junk_byte());
        end
        push_crlf();
    endtask

    task automatic add_chunk_tail();
        if ($urandom_range(0, 6) == 0) begin
            body_q.push_back(t_byte'($urandom_range(0, 255)));
            body_q.push_back(t_byte'($urandom_range(0, 255)));
        end else begin
            push_crlf();
        end
    endtask

    task automatic add_message();
        int unsigned sz;
        repeat ($urandom_range(0, 3)) begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48)
                                             : $urandom_range(1, 12);
            add_size_line(sz);
            repeat (sz) body_q.push_back(t_byte'($urandom_range(0, 255)));
            add_chunk_tail();
        end
        add_size_line(0);
        add_chunk_tail();
    endtask

    // ---------------- sender ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.data_byte <= 8'h00;
            src_gap         <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                decode_byte(in_ch.data_byte);
                n_sent <= n_sent + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap     <= src_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (body_q.size() > 0) begin
                    in_ch.valid     <= 1'b1;
                    in_ch.data_byte <= body_q.pop_front();
                    if (body_q.size() > TAIL_LEN && $urandom_range(0, 5) == 0)
                        src_gap <= $urandom_range(1, 4);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver and checker ----------------
    always @(posedge i_clk) begin : rx_check
        t_dec_beat want;
        t_dec_beat got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            sink_gap     <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{data: out_ch.out_byte, eob: out_ch.end_of_body,
                        ovf: out_ch.size_overflow};
                if (decoded_q.size() == 0) begin
                    n_err = n_err + 1;
                    if (n_err <= 10)
                        $display("ERROR: unexpected beat byte=%02h eob=%0b ovf=%0b",
                                 got.data, got.eob, got.ovf);
                end else begin
                    want = decoded_q.pop_front();
                    if (got !== want) begin
                        n_err = n_err + 1;
                        if (n_err <= 10)
                            $display({"ERROR: beat mismatch exp byte=%02h eob=%0b ",
                                      "ovf=%0b, got byte=%02h eob=%0b ovf=%0b"},
                                     want.data, want.eob, want.ovf,
                                     got.data, got.eob, got.ovf);
                    end
                    if (want.eob) n_end = n_end + 1;
                    else n_payload = n_payload + 1;
                    if (want.ovf) n_ovf_beats = n_ovf_beats + 1;
                end
            end
            if (sink_gap > 0) begin
                sink_gap     <= sink_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (body_q.size() > TAIL_LEN && $urandom_range(0, 4) == 0) begin
                sink_gap     <= $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !stall_hold;
            end
        end
    end

    // long back-pressure stretch while the sender keeps offering bytes
    initial begin
        stall_hold = 1'b0;
        wait (n_sent >= 150);
        @(posedge i_clk);
        stall_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        stall_hold <= 1'b0;
    end

    // ---------------- main sequence ----------------
    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        out_ch.ready    = 1'b0;
        n_sent = 0;
        n_payload = 0;
        n_end = 0;
        n_ovf_beats = 0;
        n_err = 0;
        m_phase = SIZE_LINE;
        m_size = 64'd0;
        m_left = 64'd0;
        m_cr = 1'b0;
        m_tail = 1'b0;
        m_last = 1'b0;
        m_ovf = 1'b0;

        // empty message: zero chunk right away
        push_text("0");
        push_crlf();
        push_crlf();
        // lone LF, lone CR, CR followed by a non-LF, non-hex neighbors of digit ranges
        body_q.push_back(CH_LF);
        body_q.push_back(CH_CR);
        push_text("0");
        body_q.push_back(CH_CR);
        push_text("x2;/:@G`g");
        push_crlf();
        body_q.push_back(8'h00);
        body_q.push_back(8'hFF);
        push_text("xy");            // trailer bytes are not checked for CR LF
        push_text("0");
        push_crlf();
        push_crlf();

        while (body_q.size() < RAND_LEN) add_message();

        // size saturates: eight F's hit the top, one more digit overflows
        add_message();
        push_text("FFFFFFFF0");
        push_crlf();
        repeat (30) body_q.push_back(t_byte'($urandom_range(0, 255)));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (body_q.size() != 0 || in_ch.valid || decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Decoded %0d body bytes into %0d payload beats and %0d end-of-body beats",
                 n_sent, n_payload, n_end);
        $display("%0d beats carried the size overflow flag; %0d mismatches",
                 n_ovf_beats, n_err);
        if (n_err == 0 && decoded_q.size() == 0) begin
            $display("http_chunked_body_decoder test passed");
        end else begin
            $display("http_chunked_body_decoder test failed");
        end
        $finish;
    end

endmodule
